@@ hdl/swlqa_pkg.sv @@
// Shared types and constants of the windowed link-quality average.
package swlqa_pkg;

	localparam int AVG_W     = 32;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;
	localparam int SHOWN_W   = 9;

	localparam logic [SHOWN_W-1:0] SHOWN_MAX = 9'd511;

	localparam logic [CFG_IDX_W-1:0] REG_LOUNGE_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd1;

	localparam logic [CFG_W-1:0] LOUNGE_RESET = 8'd1;
	localparam logic [CFG_W-1:0] WINDOW_RESET = 8'd100;

	localparam logic MODE_FLUSH = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [7:0]  probe;
		logic [15:0] seq_incoming;
		logic [15:0] seq_newest;
	} item_t;

	typedef struct packed {
		logic [SHOWN_W-1:0] average_value;
		logic               changed;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECAY,
		ST_DECAY_WAIT,
		ST_ADD,
		ST_ADD_WAIT,
		ST_SHOW,
		ST_SHOW_WAIT,
		ST_FINISH
	} state_t;

endpackage

@@ hdl/swlqa_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
module swlqa_div #(
	parameter int DIV_W = 17
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [swlqa_pkg::AVG_W-1:0] dividend,
	input  logic [DIV_W-1:0]            divisor,
	output logic                        busy,
	output logic                        done,
	output logic [swlqa_pkg::AVG_W-1:0] quotient
);
	import swlqa_pkg::*;

	localparam int CNT_W = $clog2(AVG_W + 1);

	logic [AVG_W-1:0] quot_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] divisor_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             fits;

	always_comb begin
		trial = {rem_q, quot_q[AVG_W-1]};
		diff  = trial - {1'b0, divisor_q};
		fits  = trial >= {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(AVG_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quot_q <= {quot_q[AVG_W-2:0], fits};
		end
	end

	assign busy     = (cnt_q != '0);
	assign done     = done_q;
	assign quotient = quot_q;

endmodule

@@ hdl/seqno_windowed_link_quality_average.sv @@
// Top level of the sequence-indexed link-quality moving average.
// One item at a time. A flush, or an update that leaves the record untouched, goes from
// acceptance straight to the finish state and from there into the output register. An update
// that acts runs a division for each decay step (stopping early once the average is zero) and
// closes the decay loop, then runs one for the probe addition unless the probe is zero, then one
// for the shown value, and then loads the output register. Every division runs through one shared
// bit-serial divider that produces one quotient bit per cycle over 32 bits. A gap of window_size
// or more clears the average and skips the decay loop. With window_size 255 an item can take up
// to 254 decay steps. The block is ready for the next item in the same cycle as the result
// appears, and a result still waiting downstream holds the block in its finish state.
module seqno_windowed_link_quality_average #(
	parameter int SCALE      = 100,
	parameter int MAX_LOUNGE = 10,
	parameter int MAX_WINDOW = 250,
	parameter int SEQ_BITS   = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  swlqa_pkg::item_t                item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output swlqa_pkg::result_t              result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [swlqa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [swlqa_pkg::CFG_W-1:0]     cfg_data
);
	import swlqa_pkg::*;

	localparam int SCALE_W = $clog2(SCALE + 1);
	localparam int DIV_W   = (SCALE_W > CFG_W) ? SCALE_W : CFG_W;
	localparam logic [SEQ_BITS-1:0] FLUSH_BACK = SEQ_BITS'(MAX_LOUNGE + MAX_WINDOW + 1);

	state_t state_q, state_d;

	logic [CFG_W-1:0]    lounge_q;
	logic [CFG_W-1:0]    window_q;
	logic [AVG_W-1:0]    avg_q;
	logic [SEQ_BITS-1:0] cleared_q;
	logic [SHOWN_W-1:0]  shown_q;
	logic [CFG_W-1:0]    weight_q;
	logic [7:0]          probe_q;
	logic [CFG_W-1:0]    cnt_q;
	result_t             res_q;
	logic                result_valid_q;
	result_t             result_q;

	logic [SEQ_BITS-1:0] seq_in;
	logic [SEQ_BITS-1:0] seq_max;
	logic [SEQ_BITS-1:0] upd;
	logic [SEQ_BITS-1:0] offset;
	logic [SEQ_BITS-1:0] lead;
	logic                act;
	logic                wide_gap;
	logic [CFG_W-1:0]    weight;
	logic                div_start;
	logic                div_busy;
	logic                div_done;
	logic [AVG_W-1:0]    div_dividend;
	logic [DIV_W-1:0]    div_divisor;
	logic [AVG_W-1:0]    div_quot;
	logic [AVG_W:0]      sum;
	logic [SHOWN_W-1:0]  shown_sat;
	logic                out_free;

	always_comb begin
		seq_in   = SEQ_BITS'(item.seq_incoming);
		seq_max  = SEQ_BITS'(item.seq_newest);
		lead     = seq_max - cleared_q;
		act      = (item.probe != '0) || (lead > SEQ_BITS'(lounge_q));
		upd      = (item.probe != '0) ? seq_in : (seq_max - SEQ_BITS'(lounge_q));
		offset   = upd - cleared_q;
		wide_gap = offset >= SEQ_BITS'(window_q);
		weight   = (window_q[CFG_W-1:1] == '0) ? CFG_W'(1) : CFG_W'(window_q[CFG_W-1:1]);
		sum      = {1'b0, avg_q} + {1'b0, div_quot};
		shown_sat = (div_quot > AVG_W'(SHOWN_MAX)) ? SHOWN_MAX : div_quot[SHOWN_W-1:0];
		out_free = !result_valid_q || result_ready;
		div_dividend = (state_q == ST_ADD) ? (AVG_W'(probe_q) * AVG_W'(SCALE)) : avg_q;
		div_divisor  = (state_q == ST_SHOW) ? DIV_W'(SCALE) : DIV_W'(weight_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		div_start  = 1'b0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item.mode == MODE_FLUSH || !act) begin
						state_d = ST_FINISH;
					end else if (wide_gap) begin
						state_d = ST_ADD;
					end else begin
						state_d = ST_DECAY;
					end
				end
			end
			ST_DECAY: begin
				if (cnt_q == '0 || avg_q == '0) begin
					state_d = ST_ADD;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DECAY_WAIT;
				end
			end
			ST_DECAY_WAIT: begin
				if (div_done) begin
					state_d = ST_DECAY;
				end
			end
			ST_ADD: begin
				if (probe_q == '0) begin
					state_d = ST_SHOW;
				end else begin
					div_start = 1'b1;
					state_d   = ST_ADD_WAIT;
				end
			end
			ST_ADD_WAIT: begin
				if (div_done) begin
					state_d = ST_SHOW;
				end
			end
			ST_SHOW: begin
				div_start = 1'b1;
				state_d   = ST_SHOW_WAIT;
			end
			ST_SHOW_WAIT: begin
				if (div_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lounge_q       <= LOUNGE_RESET;
			window_q       <= WINDOW_RESET;
			avg_q          <= '0;
			cleared_q      <= '0;
			shown_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_LOUNGE_SIZE: lounge_q <= cfg_data;
					REG_WINDOW_SIZE: window_q <= cfg_data;
				endcase
			end
			if (state_q == ST_FINISH && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (item.mode == MODE_FLUSH) begin
							avg_q     <= '0;
							shown_q   <= '0;
							cleared_q <= cleared_q - FLUSH_BACK;
						end else if (act) begin
							cleared_q <= upd;
							if (wide_gap) begin
								avg_q <= '0;
							end
						end
					end
				end
				ST_DECAY_WAIT: begin
					if (div_done) begin
						avg_q <= avg_q - div_quot;
					end
				end
				ST_ADD_WAIT: begin
					if (div_done) begin
						avg_q <= sum[AVG_W] ? '1 : sum[AVG_W-1:0];
					end
				end
				ST_SHOW_WAIT: begin
					if (div_done) begin
						shown_q <= shown_sat;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				weight_q <= weight;
				probe_q  <= item.probe;
				cnt_q    <= offset[CFG_W-1:0];
				if (item.mode == MODE_FLUSH) begin
					res_q <= '{average_value: '0, changed: 1'b1};
				end else begin
					res_q <= '{average_value: shown_q, changed: 1'b0};
				end
			end
			ST_DECAY_WAIT: begin
				if (div_done) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_SHOW_WAIT: begin
				if (div_done) begin
					res_q <= '{average_value: shown_sat, changed: 1'b1};
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					result_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	swlqa_div #(
		.DIV_W(DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while previous item in progress");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !div_busy)
		else $error("divider running while idle");

endmodule
